@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decoder modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define LWD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define LWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ rtl/lwd_pkg.sv @@
// Package for the LZSS window decoder: widths, constants and the
// command/status structs between controller and datapath. No dependencies.
package lwd_pkg;

  localparam int WIN_AW    = 10;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int WP_INIT   = WIN_DEPTH - 'h42;
  localparam int FILL_W    = WIN_AW + 1;
  localparam int OFS_W     = 15;
  localparam int ROW_W     = 11;
  localparam int LEN_W     = 7;
  localparam int MIN_LEN   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_COL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd3;

  typedef struct packed {
    logic accept;
    logic rd;
    logic wr;
  } lwd_cmd_t;

  typedef struct packed {
    logic copy_go;
    logic wr_hold;
    logic run_end;
    logic out_busy;
  } lwd_stat_t;

endpackage

@@ rtl/lwd_ctrl.sv @@
// Decoder controller: sequences copy reads and writes, drives input stall.
// Depends on lwd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lwd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lwd_pkg::lwd_stat_t stat_i,
  output lwd_pkg::lwd_cmd_t  cmd_o
);
  import lwd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_WR   = 3'b100
  } state_e;

  state_e st_q, st_d;
  logic   accept;

  assign in_stall_o   = (st_q != ST_IDLE) || stat_i.out_busy;
  assign accept       = in_valid_i && !in_stall_o;
  assign cmd_o.accept = accept;
  assign cmd_o.rd     = (st_q == ST_RD);
  assign cmd_o.wr     = (st_q == ST_WR);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept && stat_i.copy_go) st_d = ST_RD;
      end
      ST_RD: st_d = ST_WR;
      ST_WR: begin
        if (!stat_i.wr_hold) st_d = stat_i.run_end ? ST_IDLE : ST_RD;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  `LWD_ASSERT_NEXT(a_rd_then_wr, st_q == ST_RD, st_q == ST_WR)
  `LWD_ASSERT_NEXT(a_copy_starts, accept && stat_i.copy_go, st_q == ST_RD)
  `LWD_ASSERT_NEXT(a_hold_stays, st_q == ST_WR && stat_i.wr_hold, st_q == ST_WR)

endmodule

@@ rtl/lwd_dp.sv @@
// Decoder datapath: config registers, token parser, history window,
// offset generation and the result register. Depends on lwd_pkg, assert_macros.svh.
`include "assert_macros.svh"

module lwd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lwd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          start_image_i,
  input  logic [7:0]                    code_byte_i,
  input  lwd_pkg::lwd_cmd_t             cmd_i,
  output lwd_pkg::lwd_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lwd_pkg::OFS_W-1:0]     first_offset_o,
  output logic [7:0]                    first_byte_o,
  output logic                          second_valid_o,
  output logic [lwd_pkg::OFS_W-1:0]     second_offset_o,
  output logic [7:0]                    second_byte_o,
  output logic                          last_of_run_o,
  output logic                          image_done_o
);
  import lwd_pkg::*;

  typedef enum logic [1:0] {
    PH_SHIFT = 2'd0,
    PH_TOKEN = 2'd1,
    PH_LOW   = 2'd2
  } phase_e;

  localparam logic [WIN_AW-1:0] WpInit   = WIN_AW'(WP_INIT);
  localparam logic [FILL_W-1:0] FillFull = FILL_W'(WIN_DEPTH);

  // config
  logic             col_mode_q;
  logic [ROW_W-1:0] stride_q, height_q;
  logic [OFS_W-1:0] total_q;

  // decode state
  logic [WIN_AW-1:0] wp_q, wp_d;
  logic [15:0]       flag_q, flag_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        held_q, held_d;
  logic [OFS_W-1:0]  rem_q, rem_d;
  logic [ROW_W-1:0]  rows_q, rows_d;
  logic [OFS_W-1:0]  ofs_q, ofs_d;
  logic              fin_q, fin_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_AW-1:0] src_q, src_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              slot_full_q, slot_full_d;
  logic [OFS_W-1:0]  slot_ofs_q, slot_ofs_d;
  logic [7:0]        slot_byte_q, slot_byte_d;
  logic              rd_ok_q;
  logic [7:0]        rdata_q;
  logic              out_valid_q, out_valid_d;

  logic [7:0] mem [WIN_DEPTH];

  // base state, with start applied
  logic              start;
  logic [WIN_AW-1:0] base_wp;
  logic [15:0]       base_flag;
  phase_e            base_phase;
  logic [OFS_W-1:0]  base_rem, base_ofs;
  logic [ROW_W-1:0]  base_rows;
  logic              base_fin;
  logic [FILL_W-1:0] base_fill;

  logic        dec_en, is_shift, is_low, load_flag, lit;
  logic [15:0] f_sh, f_eff, info;

  logic             put_en;
  logic [7:0]       put_byte;
  logic [OFS_W-1:0] ofs_a, ofs_n;
  logic [ROW_W-1:0] rows_a, rows_n;
  logic [OFS_W-1:0] rem_n;
  logic             fin_n;

  logic [7:0]       v;
  logic [LEN_W-1:0] cnt_n;
  logic             run_end, need_emit, out_free, hold, emit_lit, emit_wr;
  logic [WIN_AW-1:0] rd_diff;

  assign start      = cmd_i.accept && start_image_i;
  assign base_wp    = start ? WpInit : wp_q;
  assign base_flag  = start ? 16'h0 : flag_q;
  assign base_phase = start ? PH_SHIFT : phase_q;
  assign base_rem   = start ? total_q : rem_q;
  assign base_rows  = start ? height_q : rows_q;
  assign base_ofs   = start ? '0 : ofs_q;
  assign base_fin   = start ? (total_q == '0) : fin_q;
  assign base_fill  = start ? '0 : fill_q;

  assign dec_en    = cmd_i.accept && !base_fin;
  assign is_shift  = (base_phase == PH_SHIFT);
  assign is_low    = (base_phase == PH_LOW);
  assign f_sh      = {1'b0, base_flag[15:1]};
  assign f_eff     = is_shift ? f_sh : base_flag;
  assign load_flag = is_shift && (f_sh[15:8] == 8'h00);
  assign lit       = !is_low && !load_flag && f_eff[0];
  assign info      = {held_q, code_byte_i};

  // copy byte step
  assign v         = rd_ok_q ? rdata_q : 8'h00;
  assign cnt_n     = cnt_q - LEN_W'(1);
  assign run_end   = (cnt_n == '0) || fin_n;
  assign need_emit = slot_full_q || run_end;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign hold      = cmd_i.wr && need_emit && !out_free;

  assign emit_lit = dec_en && lit;
  assign emit_wr  = cmd_i.wr && !hold && need_emit;
  assign put_en   = emit_lit || (cmd_i.wr && !hold);
  assign put_byte = cmd_i.wr ? v : code_byte_i;

  // offset / count update for one written byte
  always_comb begin
    ofs_a  = base_ofs + OFS_W'(stride_q);
    rows_a = base_rows - ROW_W'(1);
    if (col_mode_q) begin
      if (rows_a == '0) begin
        ofs_n  = ofs_a - (total_q - OFS_W'(1));
        rows_n = height_q;
      end else begin
        ofs_n  = ofs_a;
        rows_n = rows_a;
      end
    end else begin
      ofs_n  = base_ofs + OFS_W'(1);
      rows_n = base_rows;
    end
    rem_n = base_rem - OFS_W'(1);
    fin_n = (rem_n == '0);
  end

  always_comb begin
    wp_d        = wp_q;
    flag_d      = flag_q;
    phase_d     = phase_q;
    held_d      = held_q;
    rem_d       = rem_q;
    rows_d      = rows_q;
    ofs_d       = ofs_q;
    fin_d       = fin_q;
    fill_d      = fill_q;
    src_d       = src_q;
    cnt_d       = cnt_q;
    slot_full_d = slot_full_q;
    slot_ofs_d  = slot_ofs_q;
    slot_byte_d = slot_byte_q;

    if (cmd_i.accept) begin
      wp_d    = base_wp;
      flag_d  = base_flag;
      phase_d = base_phase;
      held_d  = start ? 8'h00 : held_q;
      rem_d   = base_rem;
      rows_d  = base_rows;
      ofs_d   = base_ofs;
      fin_d   = base_fin;
      fill_d  = base_fill;
      if (!base_fin) begin
        if (is_low) begin
          phase_d     = PH_SHIFT;
          src_d       = info[WIN_AW-1:0];
          cnt_d       = {1'b0, info[15:10]} + LEN_W'(MIN_LEN);
          slot_full_d = 1'b0;
        end else if (load_flag) begin
          flag_d  = {8'hFF, code_byte_i};
          phase_d = PH_TOKEN;
        end else if (lit) begin
          flag_d  = f_eff;
          phase_d = PH_SHIFT;
        end else begin
          flag_d  = f_eff;
          held_d  = code_byte_i;
          phase_d = PH_LOW;
        end
      end
    end

    if (cmd_i.wr && !hold) begin
      cnt_d = cnt_n;
      src_d = src_q + WIN_AW'(1);
      if (need_emit) begin
        slot_full_d = 1'b0;
      end else begin
        slot_full_d = 1'b1;
        slot_ofs_d  = ofs_q;
        slot_byte_d = v;
      end
    end

    if (put_en) begin
      wp_d   = base_wp + WIN_AW'(1);
      ofs_d  = ofs_n;
      rows_d = rows_n;
      rem_d  = rem_n;
      fin_d  = fin_n;
      fill_d = (base_fill == FillFull) ? base_fill : base_fill + FILL_W'(1);
    end
  end

  assign out_valid_d = (emit_lit || emit_wr) || (out_valid_q && out_stall_i);
  assign rd_diff     = src_q - WpInit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_mode_q  <= 1'b0;
      stride_q    <= ROW_W'(1);
      height_q    <= ROW_W'(1);
      total_q     <= OFS_W'(1);
      wp_q        <= WpInit;
      flag_q      <= '0;
      phase_q     <= PH_SHIFT;
      held_q      <= '0;
      rem_q       <= OFS_W'(1);
      rows_q      <= ROW_W'(1);
      ofs_q       <= '0;
      fin_q       <= 1'b0;
      fill_q      <= '0;
      src_q       <= '0;
      cnt_q       <= '0;
      slot_full_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COL_MODE: col_mode_q <= cfg_data_i[0];
          CFG_STRIDE:   stride_q   <= cfg_data_i[ROW_W-1:0];
          CFG_HEIGHT:   height_q   <= cfg_data_i[ROW_W-1:0];
          CFG_TOTAL:    total_q    <= cfg_data_i[OFS_W-1:0];
          default:      ;
        endcase
      end
      wp_q        <= wp_d;
      flag_q      <= flag_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      rem_q       <= rem_d;
      rows_q      <= rows_d;
      ofs_q       <= ofs_d;
      fin_q       <= fin_d;
      fill_q      <= fill_d;
      src_q       <= src_d;
      cnt_q       <= cnt_d;
      slot_full_q <= slot_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_ofs_q  <= slot_ofs_d;
    slot_byte_q <= slot_byte_d;
    if (put_en) mem[base_wp] <= put_byte;
    if (cmd_i.rd) begin
      rdata_q <= mem[src_q];
      rd_ok_q <= ({1'b0, rd_diff} < fill_q);
    end
    if (emit_lit) begin
      first_offset_o  <= base_ofs;
      first_byte_o    <= code_byte_i;
      second_valid_o  <= 1'b0;
      second_offset_o <= '0;
      second_byte_o   <= 8'h00;
      last_of_run_o   <= 1'b1;
      image_done_o    <= fin_n;
    end else if (emit_wr) begin
      if (slot_full_q) begin
        first_offset_o  <= slot_ofs_q;
        first_byte_o    <= slot_byte_q;
        second_valid_o  <= 1'b1;
        second_offset_o <= ofs_q;
        second_byte_o   <= v;
      end else begin
        first_offset_o  <= ofs_q;
        first_byte_o    <= v;
        second_valid_o  <= 1'b0;
        second_offset_o <= '0;
        second_byte_o   <= 8'h00;
      end
      last_of_run_o <= run_end;
      image_done_o  <= run_end && fin_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.copy_go  = dec_en && is_low;
  assign stat_o.wr_hold  = hold;
  assign stat_o.run_end  = run_end;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  `LWD_ASSERT(a_fill_bound, fill_q <= FillFull)
  `LWD_ASSERT(a_no_overwrite, !(emit_lit || emit_wr) || out_free)
  `LWD_ASSERT(a_wr_needs_count, !cmd_i.wr || (cnt_q != '0))

endmodule

@@ rtl/lzss_window_decoder.sv @@
// LZSS window decoder top level: joins controller and datapath.
// Depends on lwd_pkg, lwd_ctrl and lwd_dp.
//
// Use: compressed bytes enter on the input channel (in_valid_i/in_stall_o,
// start_image_i set on the first byte of an image). Decoded bytes leave on
// the output channel (out_valid_o/out_stall_i), up to two per result, each
// with its destination offset. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle.
// A flag byte, copy-token high byte or literal holds the input only while the
// receiver stalls; a literal's result shows the next cycle. A copy holds the
// input from its low byte until the run ends: each byte is one registered
// window read and then one write, and a write waits while the receiver stalls.
// Window history is tracked by a fill count, so a start needs no clearing.
// Reset: configuration returns to row order, stride 1, height 1, total 1;
// the decoder waits for a flag byte. When the receiver stalls, the pending
// result holds, copies pause before their next result, and the input stalls.
module lzss_window_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lwd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_image_i,
  input  logic [7:0]                    code_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lwd_pkg::OFS_W-1:0]     first_offset_o,
  output logic [7:0]                    first_byte_o,
  output logic                          second_valid_o,
  output logic [lwd_pkg::OFS_W-1:0]     second_offset_o,
  output logic [7:0]                    second_byte_o,
  output logic                          last_of_run_o,
  output logic                          image_done_o
);
  import lwd_pkg::*;

  lwd_cmd_t  cmd;
  lwd_stat_t stat;

  lwd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lwd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .start_image_i   (start_image_i),
    .code_byte_i     (code_byte_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_offset_o  (first_offset_o),
    .first_byte_o    (first_byte_o),
    .second_valid_o  (second_valid_o),
    .second_offset_o (second_offset_o),
    .second_byte_o   (second_byte_o),
    .last_of_run_o   (last_of_run_o),
    .image_done_o    (image_done_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for lzss_window_decoder: directed and random compressed streams are
// checked result by result against a predictor kept inside this file.
// Depends on lwd_pkg and the lzss_window_decoder RTL.
`timescale 1ns / 100ps

module tb_top;
  import lwd_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 150;

  typedef enum logic [1:0] {PARSE_NEXT, PARSE_TOKEN, PARSE_LOW} parse_e;

  typedef struct packed {
    logic [OFS_W-1:0] first_offset;
    logic [7:0]       first_byte;
    logic             second_valid;
    logic [OFS_W-1:0] second_offset;
    logic [7:0]       second_byte;
    logic             last_of_run;
    logic             image_done;
  } out_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_COL_MODE;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 start_image_i = 1'b0;
  logic [7:0]           code_byte_i = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OFS_W-1:0]     first_offset_o;
  logic [7:0]           first_byte_o;
  logic                 second_valid_o;
  logic [OFS_W-1:0]     second_offset_o;
  logic [7:0]           second_byte_o;
  logic                 last_of_run_o;
  logic                 image_done_o;

  lzss_window_decoder i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .start_image_i, .code_byte_i,
    .out_valid_o, .out_stall_i, .first_offset_o, .first_byte_o,
    .second_valid_o, .second_offset_o, .second_byte_o,
    .last_of_run_o, .image_done_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // decoder model state
  logic             cfg_col = 1'b0;
  logic [ROW_W-1:0] cfg_stride = 11'd1;
  logic [ROW_W-1:0] cfg_height = 11'd1;
  logic [OFS_W-1:0] cfg_total = 15'd1;
  logic [7:0]       hist [0:WIN_DEPTH-1];
  logic [WIN_AW-1:0] wr_ptr;
  logic [15:0]      flags;
  parse_e           phase;
  logic [7:0]       tok_hi;
  logic [OFS_W-1:0] remaining;
  logic [ROW_W-1:0] rows_left;
  logic [OFS_W-1:0] ofs;
  bit               done_img;
  logic [7:0]       run_b [$];
  logic [OFS_W-1:0] run_o [$];

  out_beat_t pending_beats [$];
  int  errors = 0;
  int  results_checked = 0;
  int  decoded_items = 0;
  int  images_started = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  function automatic void restart_image();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) hist[i] = 8'h00;
    wr_ptr    = WIN_AW'(WP_INIT);
    flags     = '0;
    phase     = PARSE_NEXT;
    tok_hi    = '0;
    remaining = cfg_total;
    rows_left = cfg_height;
    ofs       = '0;
    done_img  = (remaining == 0);
  endfunction

  function automatic void write_out_byte(logic [7:0] v);
    hist[wr_ptr] = v;
    wr_ptr = wr_ptr + WIN_AW'(1);
    run_b.push_back(v);
    run_o.push_back(ofs);
    if (cfg_col) begin
      ofs = ofs + OFS_W'(cfg_stride);
      rows_left = rows_left - ROW_W'(1);
      if (rows_left == 0) begin
        ofs = ofs - (cfg_total - 15'd1);
        rows_left = cfg_height;
      end
    end else begin
      ofs = ofs + OFS_W'(1);
    end
    remaining = remaining - OFS_W'(1);
    if (remaining == 0) done_img = 1'b1;
  endfunction

  function automatic void decode_code_byte(bit s, logic [7:0] b);
    logic [15:0]       info;
    logic [WIN_AW-1:0] src;
    int                len;
    int                n;
    int                k;
    out_beat_t         beat;
    if (s) begin
      images_started++;
      restart_image();
    end
    if (done_img) return;
    run_b.delete();
    run_o.delete();
    if (phase == PARSE_LOW) begin
      info  = {tok_hi, b};
      src   = info[WIN_AW-1:0];
      len   = int'(info[15:10]) + MIN_LEN;
      phase = PARSE_NEXT;
      while (len != 0 && !done_img) begin
        write_out_byte(hist[src]);
        src = src + WIN_AW'(1);
        len--;
      end
    end else begin
      if (phase == PARSE_NEXT) begin
        flags = flags >> 1;
        if (flags[15:8] == 0) begin
          flags = {8'hFF, b};
          phase = PARSE_TOKEN;
          return;
        end
      end
      if (flags[0]) begin
        phase = PARSE_NEXT;
        write_out_byte(b);
      end else begin
        tok_hi = b;
        phase  = PARSE_LOW;
        return;
      end
    end
    n = (run_b.size() + 1) / 2;
    for (k = 0; k < n; k++) begin
      beat = '0;
      beat.first_offset = run_o[2*k];
      beat.first_byte   = run_b[2*k];
      if (2*k + 1 < run_b.size()) begin
        beat.second_valid  = 1'b1;
        beat.second_offset = run_o[2*k+1];
        beat.second_byte   = run_b[2*k+1];
      end
      beat.last_of_run = (k == n - 1);
      beat.image_done  = (k == n - 1) && done_img;
      pending_beats.push_back(beat);
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // result check and receiver stall
  always @(posedge clk_i) begin
    out_beat_t got;
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {first_offset_o, first_byte_o, second_valid_o, second_offset_o,
             second_byte_o, last_of_run_o, image_done_o};
      results_checked++;
      if (pending_beats.size() == 0) begin
        report("unexpected result, first_byte", got.first_byte, 0);
      end else begin
        want = pending_beats.pop_front();
        if (got.first_offset !== want.first_offset)
          report("first_offset", got.first_offset, want.first_offset);
        if (got.first_byte !== want.first_byte)
          report("first_byte", got.first_byte, want.first_byte);
        if (got.second_valid !== want.second_valid)
          report("second_valid", got.second_valid, want.second_valid);
        if (got.second_offset !== want.second_offset)
          report("second_offset", got.second_offset, want.second_offset);
        if (got.second_byte !== want.second_byte)
          report("second_byte", got.second_byte, want.second_byte);
        if (got.last_of_run !== want.last_of_run)
          report("last_of_run", got.last_of_run, want.last_of_run);
        if (got.image_done !== want.image_done)
          report("image_done", got.image_done, want.image_done);
      end
      stall_left = rx_steady ? 0 : $urandom_range(0, 5);
      out_stall_i <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic configure(bit col, int unsigned stride, int unsigned height,
                           int unsigned total);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COL_MODE;
    cfg_data_i <= CFG_W'(col);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_STRIDE;
    cfg_data_i <= CFG_W'(stride);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= CFG_W'(height);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_TOTAL;
    cfg_data_i <= CFG_W'(total);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_col    = col;
    cfg_stride = ROW_W'(stride);
    cfg_height = ROW_W'(height);
    cfg_total  = OFS_W'(total);
  endtask

  task automatic send_byte(bit s, logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_image_i <= s;
    code_byte_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (s || !done_img) decoded_items++;
    decode_code_byte(s, b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_literals();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    configure(1'b0, 1, 1, 10);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h80);
    send_byte(1'b0, 8'h01);
    drain();
  endtask

  // overlapping 66-byte copy of one literal, cut short by the total
  task automatic test_copy_cut_short();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    configure(1'b0, 1, 1, 40);
    send_byte(1'b1, 8'hFD);
    send_byte(1'b0, 8'hC3);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hBE);
    send_byte(1'b0, 8'h7E);
    send_byte(1'b0, 8'h00);
    drain();
  endtask

  task automatic test_column_order();
    configure(1'b1, 1024, 3, 32767);
    send_byte(1'b1, 8'hFD);
    send_byte(1'b0, 8'h3C);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hBE);
    drain();
    configure(1'b1, 1024, 1024, 32767);
    send_byte(1'b1, 8'hFD);
    send_byte(1'b0, 8'hA5);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hBE);
    drain();
  endtask

  task automatic test_zero_total();
    configure(1'b0, 1, 1, 0);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h5A);
    drain();
    configure(1'b0, 1, 1, 1);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h11);
    send_byte(1'b0, 8'h22);
    drain();
  endtask

  // one image of well-formed tokens, with a stray byte now and then
  task automatic run_image(int stop_at);
    logic [7:0]        flag;
    logic [WIN_AW-1:0] pos;
    logic [5:0]        len_code;
    bit                first;
    int                t;
    first = 1'b1;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    while (decoded_items < stop_at && (first || !done_img)) begin
      flag = 8'($urandom);
      send_byte(first, flag);
      first = 1'b0;
      for (t = 0; t < 8; t++) begin
        if (decoded_items >= stop_at || done_img) break;
        if ($urandom_range(0, 19) == 0 || flag[t]) begin
          send_byte(1'b0, 8'($urandom));
        end else begin
          len_code = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6));
          pos = ($urandom_range(0, 3) == 0) ? WIN_AW'($urandom)
                                            : wr_ptr - WIN_AW'($urandom_range(1, 70));
          send_byte(1'b0, {len_code, pos[9:8]});
          send_byte(1'b0, pos[7:0]);
        end
      end
    end
    if (done_img) repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
  endtask

  task automatic test_random_streams();
    int ph;
    int stop_at;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(1'b0, 1, 1, $urandom_range(10, 90));
        1: configure(1'b1, 1024, 1024, $urandom_range(10, 90));
        2: configure(1'b1, 1, 1, $urandom_range(10, 90));
        3: configure(1'($urandom_range(0, 1)), $urandom_range(1, 1024),
                     $urandom_range(1, 1024), 32767);
        default: configure(1'b1, $urandom_range(1, 1024), $urandom_range(1, 20),
                           $urandom_range(10, 90));
      endcase
      stop_at = decoded_items + 17;
      while (decoded_items < stop_at) run_image(stop_at);
      drain();
    end
  endtask

  initial begin
    restart_image();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_literals();
    test_copy_cut_short();
    test_column_order();
    test_zero_total();
    test_random_streams();
    $display("%0d code bytes decoded over %0d images, %0d results compared, %0d errors",
             decoded_items, images_started, results_checked, errors);
    $display("row and column order, stride and height 1..1024, totals 0..32767, cut copies");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
